### hw/rtl/lcgpf_pkg.sv
// Shared constants and types for the LCG pattern fill/check engine.
// No dependencies; imported by every module under hw/rtl.

package lcgpf_pkg;

    localparam int unsigned ADDR_W     = 64;  // region address register
    localparam int unsigned STATE_W    = 48;  // rand48 generator state
    localparam int unsigned WORD_W     = 32;  // memory word / pattern word
    localparam int unsigned OUT_SHIFT  = 16;  // pattern = state[47:16]
    localparam int unsigned SEED_SHIFT = 32;  // seed = addr ^ (addr >> 32)

    localparam logic [34:0]        LCG_MULT = 35'h5_DEEC_E66D;
    localparam logic [STATE_W-1:0] LCG_INC  = 48'hB;

    localparam logic [WORD_W-1:0]  COUNT_MAX = '1;

    // APB register map: 64-bit registers at byte address 8*index
    localparam int unsigned PADDR_W     = 4;
    localparam int unsigned REG_IDX_LSB = 3;
    localparam int unsigned REG_IDX_W   = PADDR_W - REG_IDX_LSB;
    localparam logic [REG_IDX_W-1:0] REG_REGION_ADDRESS = 1'b0;

    typedef struct packed {
        logic advance;   // request leaves the input register this cycle
        logic reseed;    // request carries first_word
    } step_ctrl_t;

    typedef struct packed {
        logic [WORD_W-1:0] pattern_word;
        logic [WORD_W-1:0] diff_bits;
        logic              mismatch;
        logic [WORD_W-1:0] mismatch_count;
        logic              region_done;
    } result_t;

endpackage

### hw/rtl/lcgpf_cfg.sv
// APB register block holding the region start address.
// Depends on lcgpf_pkg.

module lcgpf_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lcgpf_pkg::PADDR_W-1:0] paddr,
    input  logic [lcgpf_pkg::ADDR_W-1:0]  pwdata,
    output logic [lcgpf_pkg::ADDR_W-1:0]  prdata,
    output logic                          pready,
    output logic [lcgpf_pkg::ADDR_W-1:0]  region_address
);
    import lcgpf_pkg::*;

    logic [ADDR_W-1:0]    region_address_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[PADDR_W-1:REG_IDX_LSB];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_address_reg <= '0;
        end
        else if (wr_en && (reg_idx == REG_REGION_ADDRESS))
        begin
            region_address_reg <= pwdata;
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_REGION_ADDRESS: prdata = region_address_reg;
            default:            prdata = '0;
        endcase
    end

    assign region_address = region_address_reg;

endmodule

### hw/rtl/lcgpf_gen.sv
// rand48 generator: state register, address seeding and one constant-multiply step.
// Depends on lcgpf_pkg.

module lcgpf_gen (
    input  logic                         clk,
    input  logic                         rst_n,
    input  lcgpf_pkg::step_ctrl_t        ctrl,
    input  logic [lcgpf_pkg::ADDR_W-1:0] region_address,
    output logic [lcgpf_pkg::WORD_W-1:0] pattern_word
);
    import lcgpf_pkg::*;

    localparam int unsigned HALF_W = STATE_W / 2;
    localparam int unsigned MULT_W = $bits(LCG_MULT);
    localparam int unsigned PLO_W  = HALF_W + MULT_W;

    logic [STATE_W-1:0] state_reg;
    logic [STATE_W-1:0] state_next;
    logic [ADDR_W-1:0]  seed_full;
    logic [STATE_W-1:0] base;
    logic [PLO_W-1:0]   prod_lo;
    logic [HALF_W-1:0]  prod_hi;

    assign seed_full = region_address ^ (region_address >> SEED_SHIFT);
    assign base      = ctrl.reseed ? seed_full[STATE_W-1:0] : state_reg;

    // state * A mod 2^48, split in halves: lo*A plus (hi*A_lo) << 24
    assign prod_lo = PLO_W'(base[HALF_W-1:0]) * PLO_W'(LCG_MULT);
    assign prod_hi = HALF_W'(base[STATE_W-1:HALF_W] * LCG_MULT[HALF_W-1:0]);

    assign state_next = prod_lo[STATE_W-1:0] + {prod_hi, {HALF_W{1'b0}}} + LCG_INC;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (ctrl.advance)
        begin
            state_reg <= state_next;
        end
    end

    assign pattern_word = state_next[OUT_SHIFT +: WORD_W];

endmodule

### hw/rtl/lcgpf_check.sv
// Compare stage: differing bits, mismatch flag and saturating mismatch tally.
// Depends on lcgpf_pkg.

module lcgpf_check (
    input  logic                         clk,
    input  logic                         rst_n,
    input  lcgpf_pkg::step_ctrl_t        ctrl,
    input  logic                         mode,
    input  logic [lcgpf_pkg::WORD_W-1:0] read_word,
    input  logic                         last_word,
    input  logic [lcgpf_pkg::WORD_W-1:0] pattern_word,
    output lcgpf_pkg::result_t           result
);
    import lcgpf_pkg::*;

    logic [WORD_W-1:0] tally_reg;
    logic [WORD_W-1:0] tally_next;
    logic [WORD_W-1:0] tally_base;
    logic [WORD_W-1:0] diff;
    logic              miss;

    assign diff       = mode ? (read_word ^ pattern_word) : '0;
    assign miss       = |diff;
    // first word clears the count before this word is counted
    assign tally_base = ctrl.reseed ? '0 : tally_reg;
    assign tally_next = (miss && (tally_base != COUNT_MAX)) ? tally_base + 1'b1 : tally_base;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tally_reg <= '0;
        end
        else if (ctrl.advance)
        begin
            tally_reg <= tally_next;
        end
    end

    always_comb
    begin
        result.pattern_word   = pattern_word;
        result.diff_bits      = diff;
        result.mismatch       = miss;
        result.mismatch_count = tally_next;
        result.region_done    = last_word;
    end

endmodule

### hw/rtl/lcg_pattern_fill_check.sv
// Top level of the LCG memory test pattern engine: input register, generator,
// compare stage and result register. Depends on lcgpf_pkg, lcgpf_cfg,
// lcgpf_gen and lcgpf_check.
//
//  Channel   Dir  Signals                          Payload
//  s_*       in   s_tvalid/s_tready/s_tdata/...    read_word, tuser {first_word, mode}, tlast
//  m_*       out  m_tvalid/m_tready/m_tdata/...    pattern, diff, count, tuser mismatch, tlast
//  apb       in   psel/penable/pwrite/paddr/...    region_address at byte address 0
//
//  One request per cycle while m_tready is high; the result is registered.
//  The generator step (48-bit state times a 35-bit constant, in two partial
//  products) sits between the input register and the result register.
//  Reset clears the generator state, mismatch tally and region address.
//  With m_tready low the result holds and the input register takes one more
//  request; s_tready then drops until the result is taken.

module lcg_pattern_fill_check (
    input  logic                          clk,
    input  logic                          rst_n,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lcgpf_pkg::WORD_W-1:0]  s_tdata,   // [31:0] read_word
    input  logic [1:0]                    s_tuser,   // [0] mode, [1] first_word
    input  logic                          s_tlast,   // last_word
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [3*lcgpf_pkg::WORD_W-1:0] m_tdata,  // [31:0] pattern_word,
                                                     // [63:32] diff_bits,
                                                     // [95:64] mismatch_count
    output logic                          m_tuser,   // [0] mismatch
    output logic                          m_tlast,   // region_done
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lcgpf_pkg::PADDR_W-1:0] paddr,
    input  logic [lcgpf_pkg::ADDR_W-1:0]  pwdata,
    output logic [lcgpf_pkg::ADDR_W-1:0]  prdata,
    output logic                          pready
);
    import lcgpf_pkg::*;

    logic              in_valid_reg;
    logic              mode_reg;
    logic              first_word_reg;
    logic              last_word_reg;
    logic [WORD_W-1:0] read_word_reg;
    logic              out_valid_reg;
    result_t           out_reg;

    logic              in_accept;
    logic              stage_adv;
    step_ctrl_t        ctrl;
    logic [ADDR_W-1:0] region_address;
    logic [WORD_W-1:0] pattern_word;
    result_t           result_next;

    // advance when the result slot is empty or being drained
    assign stage_adv    = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready     = !in_valid_reg || stage_adv;
    assign in_accept    = s_tvalid && s_tready;
    assign ctrl.advance = stage_adv;
    assign ctrl.reseed  = first_word_reg;

    lcgpf_cfg u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .region_address (region_address)
    );

    lcgpf_gen u_gen (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .region_address (region_address),
        .pattern_word   (pattern_word)
    );

    lcgpf_check u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .mode         (mode_reg),
        .read_word    (read_word_reg),
        .last_word    (last_word_reg),
        .pattern_word (pattern_word),
        .result       (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (stage_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            read_word_reg  <= s_tdata;
            mode_reg       <= s_tuser[0];
            first_word_reg <= s_tuser[1];
            last_word_reg  <= s_tlast;
        end
        if (stage_adv)
        begin
            out_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.mismatch_count, out_reg.diff_bits, out_reg.pattern_word};
    assign m_tuser  = out_reg.mismatch;
    assign m_tlast  = out_reg.region_done;

    // an empty result slot must never block the input side
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid_reg && !in_valid_reg) |-> s_tready)
        else $error("s_tready low with both stages empty");

    // a held input request moves into an empty result slot on the next edge
    a_fill_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("result register not loaded from input register");

    a_flag_matches_diff: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.mismatch == (out_reg.diff_bits != '0)))
        else $error("mismatch flag disagrees with diff bits");

    // first word restarts the count: a clean first word reports zero
    a_reseed_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_adv && first_word_reg && !result_next.mismatch)
        |=> (out_reg.mismatch_count == '0))
        else $error("count not cleared on first word");

endmodule
